// ===== sv/haversine_distance_unit_assert.svh =====
// ---------------------------------------------------------------------------
// haversine_distance_unit_assert.svh
// Assertion macros for the haversine distance unit.
// ---------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_UNIT_ASSERT_SVH
`define HAVERSINE_DISTANCE_UNIT_ASSERT_SVH

// same-cycle implication
`define HDU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hdu: implication check failed");

// next-cycle implication
`define HDU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hdu: next-cycle check failed");

`endif

// ===== sv/hdu_pkg.sv =====
// ---------------------------------------------------------------------------
// hdu_pkg
// Types, constants and elaboration-time tables for the haversine unit.
// ---------------------------------------------------------------------------
package hdu_pkg;

	localparam int LAT_W            = 20;
	localparam int LON_W            = 21;
	localparam int RAD_W            = 16;
	localparam int DIST_W           = 22;
	localparam int ANGLE_FRAC_BITS  = 30;
	localparam int DEF_CORDIC_STEPS = 32;
	localparam int DW               = 36;                 // datapath width, Q5.30
	localparam int SQRT_STEPS       = ANGLE_FRAC_BITS + 1;
	localparam int RW               = 34;                 // sqrt remainder width
	localparam int MAG_W            = LON_W + 1;          // |angle| in arc-seconds
	localparam int KW               = 40;                 // arcsec-to-radian factor
	localparam int PW               = MAG_W + KW;
	localparam int LANES            = 4;
	localparam int RSHIFT           = 62 - ANGLE_FRAC_BITS;

	localparam logic [RAD_W-1:0]  RADIUS_RESET = 16'd6371;
	localparam logic [DIST_W-1:0] DIST_MAX     = 22'h3FFFFF;
	localparam logic [63:0]       Q62_ONE      = 64'd1 << 62;

	typedef logic signed [DW-1:0]            angle_t;
	typedef logic [ANGLE_FRAC_BITS:0]        frac_t;
	typedef logic [SQRT_STEPS-1:0]           root_t;
	typedef logic [RW-1:0]                   rem_t;

	localparam angle_t ONE_F = angle_t'(64'd1 << ANGLE_FRAC_BITS);

	function automatic logic [63:0] round_q62(input logic [63:0] u);
		return (u + (64'd1 << (RSHIFT - 1))) >> RSHIFT;
	endfunction

	// restoring long division for the elaboration-time tables
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [64:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[63:0], n[b]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// pi/4 = 4 atan(1/5) - atan(1/239), Q62
	function automatic logic [63:0] qp62_calc();
		logic [63:0] p;
		logic [63:0] s5;
		logic [63:0] s239;
		logic [63:0] term;
		s5 = 64'd0;
		p = udiv64(Q62_ONE, 64'd5);
		for (int k = 0; k < 40; k++) begin
			if (p != 64'd0) begin
				term = udiv64(p, 64'(2 * k + 1));
				if ((k & 1) != 0) s5 = s5 - term;
				else s5 = s5 + term;
				p = udiv64(p, 64'd25);
			end
		end
		s239 = 64'd0;
		p = udiv64(Q62_ONE, 64'd239);
		for (int k = 0; k < 40; k++) begin
			if (p != 64'd0) begin
				term = udiv64(p, 64'(2 * k + 1));
				if ((k & 1) != 0) s239 = s239 - term;
				else s239 = s239 + term;
				p = udiv64(p, 64'd57121);
			end
		end
		return 64'd4 * s5 - s239;
	endfunction

	localparam logic [63:0] QP62 = qp62_calc();

	// atan(2^-i) by its series, rounded to Q30
	function automatic logic [63:0] atan_q(input int i);
		logic [63:0] v;
		logic [63:0] term;
		v = 64'd0;
		if (i == 0) begin
			v = QP62;
		end else begin
			for (int k = 0; k < 64; k++) begin
				if (i * (2 * k + 1) <= 62) begin
					term = udiv64(64'd1 << (62 - i * (2 * k + 1)), 64'(2 * k + 1));
					if ((k & 1) != 0) v = v - term;
					else v = v + term;
				end
			end
		end
		return round_q62(v);
	endfunction

	// inverse of the squared CORDIC gain over the steps in use, at most 32 terms
	function automatic logic [63:0] k2_calc(input int steps);
		logic [63:0] k2;
		k2 = Q62_ONE >> 1;
		for (int i = 1; i < 32; i++) begin
			if (i < steps) k2 = k2 - udiv64(k2, (64'd1 << (2 * i)) + 64'd1);
		end
		return round_q62(k2);
	endfunction

	localparam angle_t PI_F      = angle_t'(round_q62(64'd4 * QP62));
	localparam angle_t HALF_PI_F = angle_t'(round_q62(64'd2 * QP62));
	localparam logic [KW-1:0] FULL_K56 = KW'((QP62 >> 6) / 64'd162000);
	localparam logic [KW-1:0] HALF_K56 = KW'((QP62 >> 6) / 64'd324000);

	// signed Q30 product, truncated toward zero
	function automatic angle_t mul_q(input angle_t a, input angle_t b);
		angle_t      ma;
		angle_t      mb;
		logic [63:0] p;
		angle_t      r;
		ma = a[DW-1] ? -a : a;
		mb = b[DW-1] ? -b : b;
		p = ma[31:0] * mb[31:0];
		r = angle_t'(p >> ANGLE_FRAC_BITS);
		return (a[DW-1] != b[DW-1]) ? -r : r;
	endfunction

endpackage

// ===== sv/hdu_if.sv =====
// ---------------------------------------------------------------------------
// hdu_if
// Valid/ready channels of the haversine unit: point pairs in, distances out.
// ---------------------------------------------------------------------------
interface hdu_point_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [hdu_pkg::LAT_W-1:0]     lat_a_arcsec;
	logic signed [hdu_pkg::LON_W-1:0]     lon_a_arcsec;
	logic signed [hdu_pkg::LAT_W-1:0]     lat_b_arcsec;
	logic signed [hdu_pkg::LON_W-1:0]     lon_b_arcsec;

	modport source (output valid, lat_a_arcsec, lon_a_arcsec, lat_b_arcsec, lon_b_arcsec,
		input ready);
	modport sink (input valid, lat_a_arcsec, lon_a_arcsec, lat_b_arcsec, lon_b_arcsec,
		output ready);
endinterface

interface hdu_dist_if;
	logic                          valid;
	logic                          ready;
	logic [hdu_pkg::DIST_W-1:0]    distance_sixteenths_km;

	modport source (output valid, distance_sixteenths_km, input ready);
	modport sink (input valid, distance_sixteenths_km, output ready);
endinterface

// ===== sv/haversine_distance_unit.sv =====
// ---------------------------------------------------------------------------
// haversine_distance_unit
// Great-circle distance of two points from signed arc-second coordinates.
// ---------------------------------------------------------------------------
//  channel  | dir | handshake    | payload
//  points   | in  | valid/ready  | lat_a, lon_a, lat_b, lon_b (arc-seconds)
//  result   | out | valid/ready  | distance_sixteenths_km
//  cfg      | in  | cfg_we       | cfg_wdata = sphere radius in km
//
//  One item per cycle while the skid entry is empty. Stages in order:
//  5 front stages, one rotation cell per step, 4 product stages, 31 sqrt
//  cells, one vectoring cell per step, 2 scaling stages, output register.
//  Reset clears all valid bits and loads the radius with 6371.
//  Output register plus one skid entry: the pipeline stalls as a whole only
//  while the skid entry is full; points.ready is that register inverted.
// ---------------------------------------------------------------------------
module haversine_distance_unit #(
	parameter int CORDIC_STEPS = hdu_pkg::DEF_CORDIC_STEPS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hdu_pkg::RAD_W-1:0] cfg_wdata,
	hdu_point_if.sink                 points,
	hdu_dist_if.source                result
);
	import hdu_pkg::*;

	localparam int N = CORDIC_STEPS;
	localparam angle_t K2_F = angle_t'(k2_calc(N));

	logic [RAD_W-1:0] radius_q;
	logic             en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			radius_q <= cfg_wdata;
		end
	end

	// ---------------- front end: arc-seconds to folded radians ----------------
	// lanes: 0 half dlat, 1 half dlon, 2 lat_a, 3 lat_b
	logic [MAG_W-1:0] ang  [LANES];
	logic [MAG_W-1:0] mag  [LANES];
	logic [PW-1:0]    rnd  [LANES];
	angle_t           zr   [LANES];
	angle_t           zf1  [LANES];
	logic [LANES-1:0] ff1;
	angle_t           zf2  [LANES];
	logic [LANES-1:0] ff2;

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [MAG_W-1:0] mag_s1  [LANES];
	logic [LANES-1:0] neg_s1, neg_s2;
	logic [PW-1:0]    prod_s2 [LANES];
	angle_t           z_s3    [LANES];
	angle_t           z_s4    [LANES];
	logic [LANES-1:0] flip_s4;
	angle_t           z_s5    [LANES];
	logic [LANES-1:0] flip_s5;

	always_comb begin
		ang[0] = {{2{points.lat_b_arcsec[LAT_W-1]}}, points.lat_b_arcsec}
			- {{2{points.lat_a_arcsec[LAT_W-1]}}, points.lat_a_arcsec};
		ang[1] = {points.lon_b_arcsec[LON_W-1], points.lon_b_arcsec}
			- {points.lon_a_arcsec[LON_W-1], points.lon_a_arcsec};
		ang[2] = {{2{points.lat_a_arcsec[LAT_W-1]}}, points.lat_a_arcsec};
		ang[3] = {{2{points.lat_b_arcsec[LAT_W-1]}}, points.lat_b_arcsec};
		for (int l = 0; l < LANES; l++) begin
			mag[l] = ang[l][MAG_W-1] ? -ang[l] : ang[l];
			rnd[l] = prod_s2[l] + (PW'(1) << (56 - ANGLE_FRAC_BITS - 1));
			zr[l]  = angle_t'(rnd[l] >> (56 - ANGLE_FRAC_BITS));
			// at most two folds by pi for any input pattern
			zf1[l] = z_s3[l];
			ff1[l] = 1'b0;
			if (z_s3[l] > HALF_PI_F) begin
				zf1[l] = z_s3[l] - PI_F;
				ff1[l] = 1'b1;
			end else if (z_s3[l] < -HALF_PI_F) begin
				zf1[l] = z_s3[l] + PI_F;
				ff1[l] = 1'b1;
			end
			zf2[l] = z_s4[l];
			ff2[l] = flip_s4[l];
			if (z_s4[l] > HALF_PI_F) begin
				zf2[l] = z_s4[l] - PI_F;
				ff2[l] = !flip_s4[l];
			end else if (z_s4[l] < -HALF_PI_F) begin
				zf2[l] = z_s4[l] + PI_F;
				ff2[l] = !flip_s4[l];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < LANES; l++) begin
				mag_s1[l]  <= mag[l];
				neg_s1[l]  <= ang[l][MAG_W-1];
				prod_s2[l] <= PW'(mag_s1[l]) * PW'((l < 2) ? HALF_K56 : FULL_K56);
				neg_s2[l]  <= neg_s1[l];
				z_s3[l]    <= neg_s2[l] ? -zr[l] : zr[l];
				z_s4[l]    <= zf1[l];
				flip_s4[l] <= ff1[l];
				z_s5[l]    <= zf2[l];
				flip_s5[l] <= ff2[l];
			end
		end
	end

	// ---------------- rotation chains: gain-scaled sine and cosine ----------------
	angle_t           rx [LANES][N+1];
	angle_t           ry [LANES][N+1];
	angle_t           rz [LANES][N+1];
	logic [N-1:0]     rv_q;
	logic [LANES-1:0] rflip_q [N];

	for (genvar l = 0; l < LANES; l++) begin : g_rot
		assign rx[l][0] = ONE_F;
		assign ry[l][0] = '0;
		assign rz[l][0] = z_s5[l];
		for (genvar s = 0; s < N; s++) begin : g_step
			hdu_cordic_cell #(.STEP(s), .VECTORING(1'b0)) u_cell (
				.clk   (clk),
				.en    (en),
				.x_in  (rx[l][s]),
				.y_in  (ry[l][s]),
				.z_in  (rz[l][s]),
				.x_out (rx[l][s+1]),
				.y_out (ry[l][s+1]),
				.z_out (rz[l][s+1])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rflip_q[0] <= flip_s5;
			for (int s = 1; s < N; s++) rflip_q[s] <= rflip_q[s-1];
		end
	end

	// ---------------- haversine term ----------------
	angle_t                c1, c2;
	logic signed [DW:0]    a_sum;
	frac_t                 a_clamp;
	logic                  v_s6, v_s7, v_s8, v_s9;
	angle_t                psd_s6, pso_s6, pc_s6;
	angle_t                t1_s7, t2_s7, cp_s7;
	angle_t                t1_s8, m_s8;
	frac_t                 a_s9, b_s9;

	always_comb begin
		c1 = rflip_q[N-1][2] ? -rx[2][N] : rx[2][N];
		c2 = rflip_q[N-1][3] ? -rx[3][N] : rx[3][N];
		a_sum = {t1_s8[DW-1], t1_s8} + {m_s8[DW-1], m_s8};
		if (a_sum[DW]) a_clamp = '0;
		else if (a_sum > (DW+1)'(ONE_F)) a_clamp = frac_t'(ONE_F);
		else a_clamp = a_sum[ANGLE_FRAC_BITS:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psd_s6 <= mul_q(ry[0][N], ry[0][N]);
			pso_s6 <= mul_q(ry[1][N], ry[1][N]);
			pc_s6  <= mul_q(c1, c2);
			t1_s7  <= mul_q(psd_s6, K2_F);
			t2_s7  <= mul_q(pso_s6, K2_F);
			cp_s7  <= mul_q(pc_s6, K2_F);
			t1_s8  <= t1_s7;
			m_s8   <= mul_q(cp_s7, t2_s7);
			a_s9   <= a_clamp;
			b_s9   <= frac_t'(ONE_F) - a_clamp;
		end
	end

	// ---------------- square roots of a and 1 - a ----------------
	frac_t                 sv   [2][SQRT_STEPS+1];
	rem_t                  srem [2][SQRT_STEPS+1];
	root_t                 sroot[2][SQRT_STEPS+1];
	logic [SQRT_STEPS-1:0] sv_q;

	assign sv[0][0] = a_s9;
	assign sv[1][0] = b_s9;

	for (genvar q = 0; q < 2; q++) begin : g_sqrt
		assign srem[q][0]  = '0;
		assign sroot[q][0] = '0;
		for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_bit
			hdu_sqrt_cell #(.BIT(SQRT_STEPS - 1 - s)) u_cell (
				.clk      (clk),
				.en       (en),
				.v_in     (sv[q][s]),
				.rem_in   (srem[q][s]),
				.root_in  (sroot[q][s]),
				.v_out    (sv[q][s+1]),
				.rem_out  (srem[q][s+1]),
				.root_out (sroot[q][s+1])
			);
		end
	end

	// ---------------- vectoring chain: atan2(sqrt a, sqrt(1 - a)) ----------------
	angle_t       ax [N+1];
	angle_t       ay [N+1];
	angle_t       az [N+1];
	logic [N-1:0] av_q;

	assign ax[0] = angle_t'(sroot[1][SQRT_STEPS]);
	assign ay[0] = angle_t'(sroot[0][SQRT_STEPS]);
	assign az[0] = '0;

	for (genvar s = 0; s < N; s++) begin : g_vec
		hdu_cordic_cell #(.STEP(s), .VECTORING(1'b1)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_in  (ax[s]),
			.y_in  (ay[s]),
			.z_in  (az[s]),
			.x_out (ax[s+1]),
			.y_out (ay[s+1]),
			.z_out (az[s+1])
		);
	end

	// ---------------- scale by radius, round, saturate ----------------
	localparam int RP_W = RAD_W + 32;

	logic [31:0]       cang;
	logic [RP_W:0]     dsum;
	logic [DIST_W:0]   dfull;
	logic              v_s10, v_s11;
	logic [RP_W-1:0]   prod_s10;
	logic [DIST_W-1:0] dist_s11;

	always_comb begin
		// central angle is twice the vectoring angle, negative clamps to zero
		cang  = az[N][DW-1] ? 32'd0 : {az[N][30:0], 1'b0};
		dsum  = {1'b0, prod_s10} + ((RP_W+1)'(1) << (ANGLE_FRAC_BITS - 5));
		dfull = dsum[ANGLE_FRAC_BITS-4 +: DIST_W+1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s10 <= RP_W'(radius_q) * RP_W'(cang);
			dist_s11 <= (dfull > (DIST_W+1)'(DIST_MAX)) ? DIST_MAX : dfull[DIST_W-1:0];
		end
	end

	// ---------------- valid bits ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			rv_q  <= '0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			sv_q  <= '0;
			av_q  <= '0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s1  <= points.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			rv_q  <= {rv_q[N-2:0], v_s5};
			v_s6  <= rv_q[N-1];
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			sv_q  <= {sv_q[SQRT_STEPS-2:0], v_s9};
			av_q  <= {av_q[N-2:0], sv_q[SQRT_STEPS-1]};
			v_s10 <= av_q[N-1];
			v_s11 <= v_s10;
		end
	end

	// ---------------- output register and skid entry ----------------
	logic              out_valid_q, skid_valid_q;
	logic [DIST_W-1:0] out_dist_q, skid_dist_q;
	logic              push, take;

	assign en   = !skid_valid_q;
	assign push = en && v_s11;
	assign take = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (take) skid_valid_q <= 1'b0;
		end else if (push) begin
			if (out_valid_q && !take) skid_valid_q <= 1'b1;
			else out_valid_q <= 1'b1;
		end else if (take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) out_dist_q <= skid_dist_q;
		end else if (push) begin
			if (out_valid_q && !take) skid_dist_q <= dist_s11;
			else out_dist_q <= dist_s11;
		end
	end

	assign points.ready                  = en;
	assign result.valid                  = out_valid_q;
	assign result.distance_sixteenths_km = out_dist_q;

	// ---------------- assertions ----------------
`include "haversine_distance_unit_assert.svh"

	`HDU_ASSERT_IMP(a_skid_implies_out, clk, arst_n, skid_valid_q, out_valid_q)
	`HDU_ASSERT_IMP(a_no_push_when_full, clk, arst_n, skid_valid_q, !push)
	`HDU_ASSERT_NXT(a_blocked_push_fills_skid, clk, arst_n,
		push && out_valid_q && !result.ready, skid_valid_q)

endmodule

// ===== sv/hdu_cordic_cell.sv =====
// ---------------------------------------------------------------------------
// hdu_cordic_cell
// One CORDIC micro-rotation, rotation or vectoring mode, registered.
// ---------------------------------------------------------------------------
module hdu_cordic_cell #(
	parameter int STEP      = 0,
	parameter bit VECTORING = 1'b0
) (
	input  logic            clk,
	input  logic            en,
	input  hdu_pkg::angle_t x_in,
	input  hdu_pkg::angle_t y_in,
	input  hdu_pkg::angle_t z_in,
	output hdu_pkg::angle_t x_out,
	output hdu_pkg::angle_t y_out,
	output hdu_pkg::angle_t z_out
);
	import hdu_pkg::*;

	localparam angle_t ATAN_STEP = angle_t'(atan_q(STEP));

	angle_t xs;
	angle_t ys;
	logic   ccw;
	angle_t x_q;
	angle_t y_q;
	angle_t z_q;

	always_comb begin
		xs = x_in >>> STEP;
		ys = y_in >>> STEP;
		// vectoring drives y toward zero, rotation drives z toward zero
		ccw = VECTORING ? y_in[DW-1] : !z_in[DW-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ccw) begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ATAN_STEP;
			end else begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ATAN_STEP;
			end
		end
	end

	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;

endmodule

// ===== sv/hdu_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// hdu_sqrt_cell
// One result bit of the digit-by-digit square root of v * 2^30, registered.
// ---------------------------------------------------------------------------
module hdu_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic           clk,
	input  logic           en,
	input  hdu_pkg::frac_t v_in,
	input  hdu_pkg::rem_t  rem_in,
	input  hdu_pkg::root_t root_in,
	output hdu_pkg::frac_t v_out,
	output hdu_pkg::rem_t  rem_out,
	output hdu_pkg::root_t root_out
);
	import hdu_pkg::*;

	logic [2*SQRT_STEPS-1:0] n;
	logic [1:0]              pair;
	rem_t                    rem_sh;
	rem_t                    trial;
	logic                    ge;
	frac_t                   v_q;
	rem_t                    rem_q;
	root_t                   root_q;

	always_comb begin
		n      = {1'b0, v_in, {ANGLE_FRAC_BITS{1'b0}}};
		pair   = n[2*BIT+1 -: 2];
		rem_sh = {rem_in[RW-3:0], pair};
		trial  = RW'({root_in, 2'b01});
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_q    <= v_in;
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_in[SQRT_STEPS-2:0], ge};
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign root_out = root_q;

endmodule
